// ----- hdl/rbm_pkg.sv -----
`default_nettype none

package rbm_pkg;

  localparam int PRG_WINDOWS     = 4;
  localparam int CHR_WINDOWS     = 8;
  localparam int ROM_OFFSET_BITS = 22;

  localparam int OUT_BITS      = 22;
  localparam int PRG_BASE_BITS = 22;
  localparam int CHR_BASE_BITS = 21;
  localparam int PRG_SIZE_BITS = 23;
  localparam int CHR_SIZE_BITS = 22;
  localparam int PRG_UNIT_BITS = 13;
  localparam int CHR_UNIT_BITS = 10;
  localparam int PRG_WIN_BITS  = $clog2(PRG_WINDOWS);
  localparam int CHR_WIN_BITS  = $clog2(CHR_WINDOWS);

  localparam int ADDR_BITS = 16;
  localparam int OP_BITS   = 2;
  localparam int CODE_BITS = 2;
  localparam int SLOT_BITS = 3;
  localparam int PAGE_BITS = 9;

  // adjusted page, linear offset and its magnitude
  localparam int ADJ_BITS = 12;
  localparam int LIN_BITS = 27;
  localparam int MAG_BITS = LIN_BITS - 1;
  localparam int REM_BITS = PRG_SIZE_BITS + 1;
  localparam int CNT_BITS = $clog2(MAG_BITS + 1);
  localparam int IDX_BITS = 6;
  localparam int SH_BITS  = 5;

  localparam logic [OUT_BITS-1:0] OUT_MASK =
    OUT_BITS'((64'd1 << ROM_OFFSET_BITS) - 64'd1);

  localparam logic [PRG_SIZE_BITS-1:0] PRG_SIZE_RESET = 23'd32768;
  localparam logic [CHR_SIZE_BITS-1:0] CHR_SIZE_RESET = 22'd8192;

  localparam logic [OP_BITS-1:0] OP_XLATE_PRG = 2'd0;
  localparam logic [OP_BITS-1:0] OP_XLATE_CHR = 2'd1;
  localparam logic [OP_BITS-1:0] OP_SET_PRG   = 2'd2;
  localparam logic [OP_BITS-1:0] OP_SET_CHR   = 2'd3;

  localparam logic [CODE_BITS-1:0] PRG_CODE_BAD = 2'd3;

  localparam logic REG_PRG_SIZE = 1'b0;
  localparam logic REG_CHR_SIZE = 1'b1;

  typedef struct packed {
    logic latch;
    logic load_out;
    logic win_first;
    logic win_next;
    logic mod_load;
    logic mod_step;
    logic base_write;
  } rbm_cmd_t;

  typedef struct packed {
    logic is_xlate;
    logic set_skip;
    logic out_free;
    logic idx_ok;
    logic win_last;
    logic mod_done;
  } rbm_status_t;

endpackage

`default_nettype wire

// ----- hdl/rbm_if.sv -----
`default_nettype none

interface rbm_in_if;
  import rbm_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [OP_BITS-1:0]          operation;
  logic [ADDR_BITS-1:0]        address;
  logic [CODE_BITS-1:0]        bank_size_code;
  logic [SLOT_BITS-1:0]        bank_slot;
  logic signed [PAGE_BITS-1:0] bank_page;

  modport source (output valid, operation, address, bank_size_code, bank_slot, bank_page,
                  input ready);
  modport sink (input valid, operation, address, bank_size_code, bank_slot, bank_page,
                output ready);
endinterface

interface rbm_out_if;
  import rbm_pkg::*;

  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] rom_offset;

  modport source (output valid, rom_offset, input ready);
  modport sink (input valid, rom_offset, output ready);
endinterface

`default_nettype wire

// ----- hdl/rbm_ctrl.sv -----
`default_nettype none

module rbm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire rbm_pkg::rbm_status_t status,
  output rbm_pkg::rbm_cmd_t        cmd
);
  import rbm_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_WLOAD = 2'd2;
  localparam logic [1:0] S_WSTEP = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.is_xlate) begin
          if (status.out_free) begin
            cmd.load_out = 1'b1;
            state_next   = S_IDLE;
          end
        end else if (status.set_skip) begin
          state_next = S_IDLE;
        end else begin
          cmd.win_first = 1'b1;
          state_next    = S_WLOAD;
        end
      end
      S_WLOAD: begin
        // window indexes only grow, so the first one out of range ends the set
        if (status.idx_ok) begin
          cmd.mod_load = 1'b1;
          state_next   = S_WSTEP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_WSTEP: begin
        if (!status.mod_done) begin
          cmd.mod_step = 1'b1;
        end else begin
          cmd.base_write = 1'b1;
          if (status.win_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.win_next = 1'b1;
            state_next   = S_WLOAD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/rbm_dp.sv -----
`default_nettype none

module rbm_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic [rbm_pkg::OP_BITS-1:0]           operation,
  input  wire logic [rbm_pkg::ADDR_BITS-1:0]         address,
  input  wire logic [rbm_pkg::CODE_BITS-1:0]         bank_size_code,
  input  wire logic [rbm_pkg::SLOT_BITS-1:0]         bank_slot,
  input  wire logic signed [rbm_pkg::PAGE_BITS-1:0]  bank_page,
  input  wire logic [rbm_pkg::PRG_SIZE_BITS-1:0]     prg_rom_bytes,
  input  wire logic [rbm_pkg::CHR_SIZE_BITS-1:0]     chr_rom_bytes,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [rbm_pkg::OUT_BITS-1:0]               rom_offset,
  input  wire rbm_pkg::rbm_cmd_t                     cmd,
  output rbm_pkg::rbm_status_t                       status
);
  import rbm_pkg::*;

  // latched item
  logic [OP_BITS-1:0]          op_q;
  logic [ADDR_BITS-1:0]        addr_q;
  logic [CODE_BITS-1:0]        code_q;
  logic [SLOT_BITS-1:0]        slot_q;
  logic signed [PAGE_BITS-1:0] page_q;

  logic [PRG_BASE_BITS-1:0] prg_base [PRG_WINDOWS];
  logic [CHR_BASE_BITS-1:0] chr_base [CHR_WINDOWS];

  logic [2:0]               k;
  logic [MAG_BITS-1:0]      mag_q;
  logic                     neg_q;
  logic [REM_BITS-1:0]      rem;
  logic [CNT_BITS-1:0]      cnt;

  logic                      is_prg;
  logic [PRG_SIZE_BITS-1:0]  modulus;
  logic [2:0]                win_m1;
  logic [IDX_BITS-1:0]       idx;
  logic [SH_BITS-1:0]        unit_sh;
  logic [SH_BITS-1:0]        bank_sh;
  logic signed [ADJ_BITS-1:0] page_adj;
  logic [LIN_BITS-1:0]       page_wide;
  logic [LIN_BITS-1:0]       lin;
  logic [LIN_BITS-1:0]       lin_abs;
  logic [REM_BITS-1:0]       rem_sh;
  logic [REM_BITS-1:0]       rem_sub;
  logic [PRG_SIZE_BITS-1:0]  res;
  logic [OUT_BITS-1:0]       xlate;

  assign is_prg  = (op_q == OP_SET_PRG);
  assign modulus = is_prg ? prg_rom_bytes : PRG_SIZE_BITS'(chr_rom_bytes);
  assign win_m1  = 3'((4'd1 << code_q) - 4'd1);
  assign idx     = IDX_BITS'({3'd0, slot_q} << code_q) + IDX_BITS'(k);
  assign unit_sh = is_prg ? SH_BITS'(PRG_UNIT_BITS) : SH_BITS'(CHR_UNIT_BITS);
  assign bank_sh = unit_sh + SH_BITS'(code_q);

  // negative program page counts back from the end of the rom
  always_comb begin
    page_adj = ADJ_BITS'(page_q);
    if (is_prg && page_q < 0) begin
      page_adj = page_adj + signed'(ADJ_BITS'(prg_rom_bytes >> bank_sh));
    end
  end

  assign page_wide = LIN_BITS'(page_adj);
  assign lin       = (page_wide << bank_sh) + (LIN_BITS'(k) << unit_sh);
  assign lin_abs   = lin[LIN_BITS-1] ? (~lin + LIN_BITS'(1)) : lin;

  // one remainder bit per step
  assign rem_sh  = {rem[REM_BITS-2:0], mag_q[MAG_BITS-1]};
  assign rem_sub = rem_sh - REM_BITS'(modulus);

  // floored result for negative values, zero for a zero modulus
  always_comb begin
    if (modulus == '0) begin
      res = '0;
    end else if (neg_q && rem != '0) begin
      res = modulus - rem[PRG_SIZE_BITS-1:0];
    end else begin
      res = rem[PRG_SIZE_BITS-1:0];
    end
  end

  always_comb begin
    if (op_q == OP_XLATE_PRG) begin
      xlate = prg_base[addr_q[PRG_UNIT_BITS+PRG_WIN_BITS-1:PRG_UNIT_BITS]]
            + OUT_BITS'(addr_q[PRG_UNIT_BITS-1:0]);
    end else begin
      xlate = OUT_BITS'(chr_base[addr_q[CHR_UNIT_BITS+CHR_WIN_BITS-1:CHR_UNIT_BITS]])
            + OUT_BITS'(addr_q[CHR_UNIT_BITS-1:0]);
    end
  end

  always_comb begin
    status.is_xlate = (op_q == OP_XLATE_PRG) || (op_q == OP_XLATE_CHR);
    status.set_skip = is_prg && (code_q == PRG_CODE_BAD);
    status.out_free = !out_valid || out_ready;
    status.idx_ok   = is_prg ? (idx < IDX_BITS'(PRG_WINDOWS)) : (idx < IDX_BITS'(CHR_WINDOWS));
    status.win_last = (k == win_m1);
    status.mod_done = (cnt == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q   <= operation;
      addr_q <= address;
      code_q <= bank_size_code;
      slot_q <= bank_slot;
      page_q <= bank_page;
    end
    if (cmd.win_first) begin
      k <= '0;
    end else if (cmd.win_next) begin
      k <= k + 3'd1;
    end
    if (cmd.mod_load) begin
      mag_q <= lin_abs[MAG_BITS-1:0];
      neg_q <= lin[LIN_BITS-1];
      rem   <= '0;
    end else if (cmd.mod_step) begin
      mag_q <= {mag_q[MAG_BITS-2:0], 1'b0};
      rem   <= (rem_sh >= REM_BITS'(modulus)) ? rem_sub : rem_sh;
    end
    if (cmd.load_out) begin
      rom_offset <= xlate & OUT_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < PRG_WINDOWS; i++) begin
        prg_base[i] <= '0;
      end
      for (int i = 0; i < CHR_WINDOWS; i++) begin
        chr_base[i] <= '0;
      end
    end else begin
      if (cmd.mod_load) begin
        cnt <= CNT_BITS'(MAG_BITS);
      end else if (cmd.mod_step) begin
        cnt <= cnt - CNT_BITS'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.base_write) begin
        if (is_prg) begin
          prg_base[idx[PRG_WIN_BITS-1:0]] <= res[PRG_BASE_BITS-1:0];
        end else begin
          chr_base[idx[CHR_WIN_BITS-1:0]] <= res[CHR_BASE_BITS-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rom_bank_mapper.sv -----
`default_nettype none

// channel   dir  handshake      word
// in_ch     in   valid/ready    operation, address, bank_size_code, bank_slot, bank_page
// out_ch    out  valid/ready    rom_offset
// apb       in   psel/penable   prg_rom_bytes at 0x0, chr_rom_bytes at 0x4
//
// a translate is accepted, then the window lookup and add go into the output register
// a bank set is accepted, then walks each covered window in turn (load, 26 remainder
//   steps, write) in the bit-serial remainder unit; a full character set has 8 windows
// a set with its slot past the last window or a program size code three writes no window
// reset (rst, synchronous) clears all window bases and loads the default rom sizes
// the output register lets the next item in while a result waits; a translate only
//   stalls if the previous result is still not taken

module rom_bank_mapper (
  input  wire logic       clk,
  input  wire logic       rst,
  rbm_in_if.sink          in_ch,
  rbm_out_if.source       out_ch,
  input  wire logic       psel,
  input  wire logic       penable,
  input  wire logic       pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import rbm_pkg::*;

  // rom size registers
  logic [PRG_SIZE_BITS-1:0] prg_rom_bytes;
  logic [CHR_SIZE_BITS-1:0] chr_rom_bytes;
  logic                     cfg_write;
  logic                     reg_sel;

  rbm_cmd_t    cmd;
  rbm_status_t status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  // byte lanes ignored, word select only
  assign reg_sel   = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_rom_bytes <= PRG_SIZE_RESET;
      chr_rom_bytes <= CHR_SIZE_RESET;
    end else if (cfg_write) begin
      if (reg_sel == REG_PRG_SIZE) begin
        prg_rom_bytes <= pwdata[PRG_SIZE_BITS-1:0];
      end else begin
        chr_rom_bytes <= pwdata[CHR_SIZE_BITS-1:0];
      end
    end
  end

  assign prdata = (reg_sel == REG_PRG_SIZE) ? 32'(prg_rom_bytes) : 32'(chr_rom_bytes);

  // sequencer: accept, translate or walk the covered windows
  rbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // item latch, window bases, remainder unit, output register
  rbm_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .operation      (in_ch.operation),
    .address        (in_ch.address),
    .bank_size_code (in_ch.bank_size_code),
    .bank_slot      (in_ch.bank_slot),
    .bank_page      (in_ch.bank_page),
    .prg_rom_bytes  (prg_rom_bytes),
    .chr_rom_bytes  (chr_rom_bytes),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .rom_offset     (out_ch.rom_offset),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

`default_nettype wire
